// ===== rtl/i2c_register_io_controller_defines.svh =====
// assertion macros for the bus-slave register controller
`ifndef I2C_REGISTER_IO_CONTROLLER_DEFINES_SVH
`define I2C_REGISTER_IO_CONTROLLER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define I2CRIO_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define I2CRIO_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/i2crio_pkg.sv =====
// types, codes and tables of the bus-slave register controller
package i2crio_pkg;

  localparam int NUM_BANDS      = 23;
  localparam int PWM_FULL_SCALE = 1000;

  typedef enum logic [1:0] {
    REQ_RECEIVE = 2'd0,
    REQ_READ    = 2'd1,
    REQ_STOP    = 2'd2,
    REQ_PIN     = 2'd3
  } req_t;

  // register addresses
  localparam logic [7:0] REG_INFO    = 8'd0;
  localparam logic [7:0] REG_BUF_END = 8'd4;
  localparam logic [7:0] REG_RX_MODE = 8'd11;
  localparam logic [7:0] REG_FAN     = 8'd12;
  localparam logic [7:0] REG_FREQ    = 8'd13;

  // receive-input modes
  localparam logic [7:0] MODE_OFF = 8'd0;
  localparam logic [7:0] MODE_ON  = 8'd1;
  localparam logic [7:0] MODE_PIN = 8'd2;

  // read positions of the info register
  localparam logic [7:0] POS_MAJOR = 8'd0;
  localparam logic [7:0] POS_MINOR = 8'd1;
  localparam logic [7:0] POS_PINS  = 8'd2;
  localparam logic [7:0] POS_ID    = 8'd3;

  localparam logic [7:0] RD_ID   = 8'hFE;
  localparam logic [7:0] RD_NONE = 8'hFF;
  localparam logic [7:0] RD_IDLE = 8'h00;

  // configuration register indexes
  localparam logic CFG_VERSION_MAJOR = 1'b0;
  localparam logic CFG_VERSION_MINOR = 1'b1;

  localparam logic [4:0] BAND_RESET = 5'd8;

  // fan level = data * full scale / 255 as a reciprocal multiply, exact for 8-bit data
  localparam int          FAN_SHIFT  = 26;
  localparam longint      FAN_RECIP  = (64'd1 << FAN_SHIFT) / 255 + 1;
  localparam longint      FAN_MULT   = PWM_FULL_SCALE * FAN_RECIP;
  localparam int          FAN_PROD_W = 40;

  typedef logic [39:0] freq_t;
  typedef freq_t edge_tab_t [NUM_BANDS + 1];
  typedef logic [9:0] level_tab_t [NUM_BANDS + 1];
  typedef logic [12:0] mv_tab_t [NUM_BANDS + 1];

  localparam edge_tab_t BAND_EDGE = '{
    40'd0, 40'd300000, 40'd1000000, 40'd2500000, 40'd4500000, 40'd6000000,
    40'd8000000, 40'd11000000, 40'd16000000, 40'd19000000, 40'd22000000,
    40'd25000000, 40'd32000000, 40'd60000000, 40'd90000000, 40'd155000000,
    40'd300000000, 40'd500000000, 40'd1000000000, 40'd2000000000,
    40'd3000000000, 40'd4000000000, 40'd7000000000, 40'd11000000000
  };

  // band voltage in millivolts, zero where a band has none
  localparam mv_tab_t BAND_MV = '{
    13'd0, 13'd0, 13'd0, 13'd330, 13'd670, 13'd830, 13'd1000, 13'd1330,
    13'd1670, 13'd2000, 13'd2330, 13'd2670, 13'd3000, 13'd3330, 13'd0,
    13'd3670, 13'd0, 13'd4000, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0
  };

  function automatic level_tab_t make_levels();
    level_tab_t t;
    for (int i = 0; i <= NUM_BANDS; i++) begin
      t[i] = 10'(PWM_FULL_SCALE * int'(BAND_MV[i]) / 5000);
    end
    return t;
  endfunction

  localparam level_tab_t BAND_LEVEL = make_levels();

  typedef struct packed {
    req_t       req_type;
    logic [7:0] wr_data;
    logic [4:0] in_pins;
    logic       exttr_pin;
  } item_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] band;
    logic       hpf;
    logic [9:0] level;
  } band_sel_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       rd_valid;
    logic [9:0] fan_level;
    logic [7:0] rx_mode;
    logic       inttr_on;
    logic       rf3_on;
    freq_t      tx_freq;
    logic [4:0] band_number;
    logic       hpf_on;
    logic [9:0] band_volt_level;
  } result_t;

endpackage

// ===== rtl/i2c_register_io_controller.sv =====
// top level of the bus-slave register controller
//
//   channel  direction  handshake            payload
//   in       receive    in_valid / in_stall  req_type wr_data in_pins exttr_pin
//   out      send       out_valid/out_stall  rd_data .. band_volt_level
//   cfg      receive    cfg_wr_en            cfg_index cfg_data
//
// a word can be taken every cycle unless the output stalls; its result reaches the output through
// the input register, then event decode and band lookup into the result register
// the band lookup is 22 parallel compares of the 40-bit frequency
// reset sets the valid flags and state registers, not the input and result data; no clearing pass
// a stalled result holds the result register and the input register behind it
`include "i2c_register_io_controller_defines.svh"

module i2c_register_io_controller (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              req_type,
  input  logic [7:0]              wr_data,
  input  logic [4:0]              in_pins,
  input  logic                    exttr_pin,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              rd_data,
  output logic                    rd_valid,
  output logic [9:0]              fan_level,
  output logic [7:0]              rx_mode,
  output logic                    inttr_on,
  output logic                    rf3_on,
  output logic [39:0]             tx_freq,
  output logic [4:0]              band_number,
  output logic                    hpf_on,
  output logic [9:0]              band_volt_level,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_index,
  input  logic [7:0]              cfg_data
);
  import i2crio_pkg::*;

  logic       stage_valid;
  item_t      stage_item;
  logic       out_free;
  logic       fire;
  logic       take;
  result_t    res_next;
  result_t    res;
  logic [7:0] version_major;
  logic [7:0] version_minor;
  logic       band_ok;
  logic       hpf_ok;
  logic       fan_ok;

  assign out_free = !out_valid || !out_stall;
  assign fire     = stage_valid && out_free;
  assign in_stall = stage_valid && !out_free;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      version_major <= 8'd1;
      version_minor <= 8'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_VERSION_MAJOR: version_major <= cfg_data;
        CFG_VERSION_MINOR: version_minor <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_item <= '{req_type: req_t'(req_type), wr_data: wr_data,
                      in_pins: in_pins, exttr_pin: exttr_pin};
    end
  end

  i2crio_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .item          (stage_item),
    .version_major (version_major),
    .version_minor (version_minor),
    .res           (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign rd_data         = res.rd_data;
  assign rd_valid        = res.rd_valid;
  assign fan_level       = res.fan_level;
  assign rx_mode         = res.rx_mode;
  assign inttr_on        = res.inttr_on;
  assign rf3_on          = res.rf3_on;
  assign tx_freq         = res.tx_freq;
  assign band_number     = res.band_number;
  assign hpf_on          = res.hpf_on;
  assign band_volt_level = res.band_volt_level;

  assign band_ok = (band_number >= 5'd1) && (band_number <= 5'(NUM_BANDS));
  assign hpf_ok  = (hpf_on == (band_number > 5'd3)) || (band_number == BAND_RESET);
  assign fan_ok  = fan_level <= 10'(PWM_FULL_SCALE);

  `I2CRIO_ASSERT_NEXT(a_fire_shows, clk, rst, fire, out_valid, "processed word not shown")
  `I2CRIO_ASSERT_NOW(a_band_range, clk, rst, out_valid, band_ok, "band out of range")
  `I2CRIO_ASSERT_NOW(a_hpf_band, clk, rst, out_valid, hpf_ok, "filter switch disagrees with band")
  `I2CRIO_ASSERT_NOW(a_fan_range, clk, rst, out_valid, fan_ok, "fan level above full scale")

endmodule

// ===== rtl/i2crio_band.sv =====
// band lookup: current-band check and search over the cutoff table
module i2crio_band (
  input  i2crio_pkg::freq_t     freq,
  input  logic [4:0]            cur_band,
  output i2crio_pkg::band_sel_t sel
);
  import i2crio_pkg::*;

  logic [NUM_BANDS-2:0] above;
  logic                 cur_ok;
  logic [4:0]           found;

  always_comb begin
    for (int i = 1; i < NUM_BANDS; i++) begin
      above[i-1] = freq > BAND_EDGE[i];
    end
  end

  assign cur_ok = (cur_band >= 5'd1) && (cur_band <= 5'(NUM_BANDS)) &&
                  (BAND_EDGE[5'(cur_band - 5'd1)] <= freq) &&
                  (freq <= BAND_EDGE[cur_band]);

  assign found = 5'($countones(above)) + 5'd1;

  assign sel.hit   = cur_ok;
  assign sel.band  = found;
  assign sel.hpf   = found > 5'd3;
  assign sel.level = BAND_LEVEL[found];

endmodule

// ===== rtl/i2crio_regs.sv =====
// register file and event decode of the controller
module i2crio_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  i2crio_pkg::item_t   item,
  input  logic [7:0]          version_major,
  input  logic [7:0]          version_minor,
  output i2crio_pkg::result_t res
);
  import i2crio_pkg::*;

  logic [7:0]      selected_register, selected_register_next;
  logic            reg_selected, reg_selected_next;
  logic [7:0]      read_position, read_position_next;
  logic [7:0]      byte_buffers [4];
  logic [7:0]      byte_buffers_next [4];
  logic [7:0]      usage_mode, usage_mode_next;
  logic            inttr_level, inttr_level_next;
  logic            rf3_level, rf3_level_next;
  logic [9:0]      fan_pwm_level, fan_pwm_level_next;
  freq_t           frequency, frequency_next;
  logic [4:0]      band_index, band_index_next;
  logic            hpf_level, hpf_level_next;
  logic [9:0]      band_pwm_level, band_pwm_level_next;
  logic [7:0]      rd;
  logic            rv;
  freq_t           freq_new;
  logic [FAN_PROD_W-1:0] fan_prod;
  band_sel_t       band_sel;

  assign freq_new = {byte_buffers[0], byte_buffers[1], byte_buffers[2],
                     byte_buffers[3], item.wr_data};
  assign fan_prod = FAN_PROD_W'(item.wr_data) * FAN_PROD_W'(FAN_MULT);

  i2crio_band u_band (
    .freq     (freq_new),
    .cur_band (band_index),
    .sel      (band_sel)
  );

  always_comb begin
    selected_register_next = selected_register;
    reg_selected_next      = reg_selected;
    read_position_next     = read_position;
    byte_buffers_next      = byte_buffers;
    usage_mode_next        = usage_mode;
    inttr_level_next       = inttr_level;
    rf3_level_next         = rf3_level;
    fan_pwm_level_next     = fan_pwm_level;
    frequency_next         = frequency;
    band_index_next        = band_index;
    hpf_level_next         = hpf_level;
    band_pwm_level_next    = band_pwm_level;
    rd                     = RD_IDLE;
    rv                     = 1'b0;
    unique case (item.req_type)
      REQ_RECEIVE: begin
        if (!reg_selected) begin
          selected_register_next = item.wr_data;
          reg_selected_next      = 1'b1;
        end else if (selected_register < REG_BUF_END) begin
          byte_buffers_next[selected_register[1:0]] = item.wr_data;
        end else if (selected_register == REG_RX_MODE) begin
          usage_mode_next = item.wr_data;
          case (item.wr_data)
            MODE_OFF: begin
              inttr_level_next = 1'b0;
              rf3_level_next   = 1'b0;
            end
            MODE_ON: begin
              inttr_level_next = 1'b1;
              rf3_level_next   = 1'b1;
            end
            MODE_PIN: inttr_level_next = 1'b1;
            default: ;
          endcase
        end else if (selected_register == REG_FAN) begin
          fan_pwm_level_next = fan_prod[FAN_SHIFT +: 10];
        end else if (selected_register == REG_FREQ) begin
          if (freq_new != frequency) begin
            frequency_next = freq_new;
            if (!band_sel.hit) begin
              band_index_next     = band_sel.band;
              hpf_level_next      = band_sel.hpf;
              band_pwm_level_next = band_sel.level;
            end
          end
        end
      end
      REQ_READ: begin
        rv                 = 1'b1;
        read_position_next = read_position + 8'd1;
        if (selected_register == REG_INFO) begin
          case (read_position)
            POS_MAJOR: rd = version_major;
            POS_MINOR: rd = version_minor;
            POS_PINS:  rd = {2'b00, item.in_pins, item.exttr_pin};
            POS_ID:    rd = RD_ID;
            default:   rd = RD_NONE;
          endcase
        end else begin
          rd = RD_NONE;
        end
      end
      REQ_STOP: begin
        reg_selected_next  = 1'b0;
        read_position_next = 8'd0;
      end
      REQ_PIN: ;
      default: ;
    endcase
    // pin following
    if (usage_mode_next == MODE_PIN) begin
      rf3_level_next = item.exttr_pin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_register <= RD_NONE;
      reg_selected      <= 1'b0;
      read_position     <= 8'd0;
      for (int i = 0; i < 4; i++) begin
        byte_buffers[i] <= 8'd0;
      end
      usage_mode        <= MODE_OFF;
      inttr_level       <= 1'b0;
      rf3_level         <= 1'b0;
      fan_pwm_level     <= 10'd0;
      frequency         <= '0;
      band_index        <= BAND_RESET;
      hpf_level         <= 1'b0;
      band_pwm_level    <= 10'd0;
    end else if (fire) begin
      selected_register <= selected_register_next;
      reg_selected      <= reg_selected_next;
      read_position     <= read_position_next;
      byte_buffers      <= byte_buffers_next;
      usage_mode        <= usage_mode_next;
      inttr_level       <= inttr_level_next;
      rf3_level         <= rf3_level_next;
      fan_pwm_level     <= fan_pwm_level_next;
      frequency         <= frequency_next;
      band_index        <= band_index_next;
      hpf_level         <= hpf_level_next;
      band_pwm_level    <= band_pwm_level_next;
    end
  end

  assign res.rd_data         = rd;
  assign res.rd_valid        = rv;
  assign res.fan_level       = fan_pwm_level_next;
  assign res.rx_mode         = usage_mode_next;
  assign res.inttr_on        = inttr_level_next;
  assign res.rf3_on          = rf3_level_next;
  assign res.tx_freq         = frequency_next;
  assign res.band_number     = band_index_next;
  assign res.hpf_on          = hpf_level_next;
  assign res.band_volt_level = band_pwm_level_next;

endmodule

// ===== test/tb_top.sv =====
// testbench for the bus-slave register controller: directed and random bus events
`timescale 1ns / 1ps

module tb_top;
  import i2crio_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int LATENCY = 2;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] REG_UNUSED = 8'd200;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall;
  logic [1:0] req_type;
  logic [7:0] wr_data;
  logic [4:0] in_pins;
  logic exttr_pin;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] rd_data;
  logic rd_valid;
  logic [9:0] fan_level;
  logic [7:0] rx_mode;
  logic inttr_on, rf3_on;
  logic [39:0] tx_freq;
  logic [4:0] band_number;
  logic hpf_on;
  logic [9:0] band_volt_level;
  logic cfg_wr_en, cfg_index;
  logic [7:0] cfg_data;

  int errors = 0;
  int words_sent = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left = 0;

  // predictor state
  logic [7:0] ver_major, ver_minor, sel_reg, read_pos, mode_byte;
  logic sel_done, inttr_lvl, rf3_lvl, hpf_lvl;
  logic [7:0] buf_byte [4];
  logic [9:0] fan_lvl, volt_lvl;
  logic [39:0] freq_hz;
  logic [4:0] band_idx;
  result_t status_due [$];

  i2c_register_io_controller uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .wr_data(wr_data), .in_pins(in_pins), .exttr_pin(exttr_pin),
    .out_valid(out_valid), .out_stall(out_stall),
    .rd_data(rd_data), .rd_valid(rd_valid), .fan_level(fan_level), .rx_mode(rx_mode),
    .inttr_on(inttr_on), .rf3_on(rf3_on), .tx_freq(tx_freq), .band_number(band_number),
    .hpf_on(hpf_on), .band_volt_level(band_volt_level),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [39:0] cutoff(int k);
    case (k)
      0: return 40'd0;
      1: return 40'd300000;
      2: return 40'd1000000;
      3: return 40'd2500000;
      4: return 40'd4500000;
      5: return 40'd6000000;
      6: return 40'd8000000;
      7: return 40'd11000000;
      8: return 40'd16000000;
      9: return 40'd19000000;
      10: return 40'd22000000;
      11: return 40'd25000000;
      12: return 40'd32000000;
      13: return 40'd60000000;
      14: return 40'd90000000;
      15: return 40'd155000000;
      16: return 40'd300000000;
      17: return 40'd500000000;
      18: return 40'd1000000000;
      19: return 40'd2000000000;
      20: return 40'd3000000000;
      21: return 40'd4000000000;
      22: return 40'd7000000000;
      default: return 40'd11000000000;
    endcase
  endfunction

  function automatic int millivolts(int b);
    case (b)
      3: return 330;
      4: return 670;
      5: return 830;
      6: return 1000;
      7: return 1330;
      8: return 1670;
      9: return 2000;
      10: return 2330;
      11: return 2670;
      12: return 3000;
      13: return 3330;
      15: return 3670;
      17: return 4000;
      default: return 0;
    endcase
  endfunction

  function automatic logic fits_band(logic [4:0] b, logic [39:0] f);
    if (b < 1 || b > NUM_BANDS) return 1'b0;
    return cutoff(int'(b) - 1) <= f && f <= cutoff(int'(b));
  endfunction

  function automatic void retune_band(logic [39:0] f);
    int b;
    if (fits_band(band_idx, f)) return;
    b = 1;
    while (b < NUM_BANDS && !fits_band(5'(b), f)) b++;
    band_idx = 5'(b);
    hpf_lvl = b > 3;
    volt_lvl = 10'(PWM_FULL_SCALE * millivolts(b) / 5000);
  endfunction

  function automatic void clear_model();
    ver_major = 8'd1;
    ver_minor = 8'd0;
    sel_reg = 8'hFF;
    sel_done = 1'b0;
    read_pos = 8'd0;
    for (int i = 0; i < 4; i++) buf_byte[i] = 8'd0;
    mode_byte = MODE_OFF;
    inttr_lvl = 1'b0;
    rf3_lvl = 1'b0;
    fan_lvl = 10'd0;
    freq_hz = 40'd0;
    band_idx = BAND_RESET;
    hpf_lvl = 1'b0;
    volt_lvl = 10'd0;
  endfunction

  function automatic result_t status_after(item_t w);
    result_t r;
    logic [39:0] f;
    r = '0;
    case (w.req_type)
      REQ_RECEIVE: begin
        if (!sel_done) begin
          sel_reg = w.wr_data;
          sel_done = 1'b1;
        end else if (sel_reg < REG_BUF_END) begin
          buf_byte[sel_reg[1:0]] = w.wr_data;
        end else if (sel_reg == REG_RX_MODE) begin
          mode_byte = w.wr_data;
          if (w.wr_data == MODE_OFF) begin
            inttr_lvl = 1'b0;
            rf3_lvl = 1'b0;
          end else if (w.wr_data == MODE_ON) begin
            inttr_lvl = 1'b1;
            rf3_lvl = 1'b1;
          end else if (w.wr_data == MODE_PIN) begin
            inttr_lvl = 1'b1;
          end
        end else if (sel_reg == REG_FAN) begin
          fan_lvl = 10'(PWM_FULL_SCALE * int'(w.wr_data) / 255);
        end else if (sel_reg == REG_FREQ) begin
          f = {buf_byte[0], buf_byte[1], buf_byte[2], buf_byte[3], w.wr_data};
          if (f != freq_hz) begin
            freq_hz = f;
            retune_band(f);
          end
        end
      end
      REQ_READ: begin
        if (sel_reg == REG_INFO) begin
          case (read_pos)
            POS_MAJOR: r.rd_data = ver_major;
            POS_MINOR: r.rd_data = ver_minor;
            POS_PINS: r.rd_data = {2'b00, w.in_pins, w.exttr_pin};
            POS_ID: r.rd_data = RD_ID;
            default: r.rd_data = RD_NONE;
          endcase
        end else begin
          r.rd_data = RD_NONE;
        end
        r.rd_valid = 1'b1;
        read_pos = read_pos + 8'd1;
      end
      REQ_STOP: begin
        sel_done = 1'b0;
        read_pos = 8'd0;
      end
      default: ;
    endcase
    if (mode_byte == MODE_PIN) rf3_lvl = w.exttr_pin;
    r.fan_level = fan_lvl;
    r.rx_mode = mode_byte;
    r.inttr_on = inttr_lvl;
    r.rf3_on = rf3_lvl;
    r.tx_freq = freq_hz;
    r.band_number = band_idx;
    r.hpf_on = hpf_lvl;
    r.band_volt_level = volt_lvl;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [39:0] want, logic [39:0] got);
    errors++;
    if (errors <= 100)
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
  endtask

  // predictor runs on every word taken
  always @(posedge clk) begin : take_words
    item_t w;
    if (rst) begin
      clear_model();
      status_due.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_VERSION_MAJOR) ver_major = cfg_data;
        else ver_minor = cfg_data;
      end
      if (in_valid && !in_stall) begin
        w.req_type = req_t'(req_type);
        w.wr_data = wr_data;
        w.in_pins = in_pins;
        w.exttr_pin = exttr_pin;
        status_due.push_back(status_after(w));
      end
    end
  end

  always @(posedge clk) begin : check_words
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        report_mismatch("word with nothing pending", 40'd0, 40'd0);
      end else begin
        want = status_due.pop_front();
        if (rd_data !== want.rd_data)
          report_mismatch("rd_data", 40'(want.rd_data), 40'(rd_data));
        if (rd_valid !== want.rd_valid)
          report_mismatch("rd_valid", 40'(want.rd_valid), 40'(rd_valid));
        if (fan_level !== want.fan_level)
          report_mismatch("fan_level", 40'(want.fan_level), 40'(fan_level));
        if (rx_mode !== want.rx_mode)
          report_mismatch("rx_mode", 40'(want.rx_mode), 40'(rx_mode));
        if (inttr_on !== want.inttr_on)
          report_mismatch("inttr_on", 40'(want.inttr_on), 40'(inttr_on));
        if (rf3_on !== want.rf3_on)
          report_mismatch("rf3_on", 40'(want.rf3_on), 40'(rf3_on));
        if (tx_freq !== want.tx_freq) report_mismatch("tx_freq", want.tx_freq, tx_freq);
        if (band_number !== want.band_number)
          report_mismatch("band_number", 40'(want.band_number), 40'(band_number));
        if (hpf_on !== want.hpf_on)
          report_mismatch("hpf_on", 40'(want.hpf_on), 40'(hpf_on));
        if (band_volt_level !== want.band_volt_level)
          report_mismatch("band_volt_level", 40'(want.band_volt_level), 40'(band_volt_level));
      end
    end
  end

  // receiver side: random stall or a long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_given != hold_asked) begin
      out_stall <= 1'b1;
      hold_given <= hold_asked;
      hold_left <= HOLD_CYCLES - 1;
    end else begin
      out_stall <= recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("i2c_register_io_controller verification failed");
        $finish;
      end
    end
  end

  // data of non-receive words is don't-care, so it is randomized
  task automatic send_word(req_t kind, logic [7:0] data);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    wr_data <= (kind == REQ_RECEIVE) ? data : 8'($urandom);
    in_pins <= 5'($urandom);
    exttr_pin <= 1'($urandom);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_version(logic idx, logic [7:0] val);
    drain_results();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic read_info(int count);
    send_word(REQ_STOP, 8'h00);
    send_word(REQ_RECEIVE, REG_INFO);
    repeat (count) send_word(REQ_READ, 8'h00);
  endtask

  // buffers that already hold the right byte are skipped
  task automatic program_freq(logic [39:0] f);
    for (int i = 0; i < 4; i++) begin
      if (buf_byte[i] != f[39 - 8 * i -: 8]) begin
        send_word(REQ_STOP, 8'h00);
        send_word(REQ_RECEIVE, REG_INFO + 8'(i));
        send_word(REQ_RECEIVE, f[39 - 8 * i -: 8]);
      end
    end
    send_word(REQ_STOP, 8'h00);
    send_word(REQ_RECEIVE, REG_FREQ);
    send_word(REQ_RECEIVE, f[7:0]);
  endtask

  function automatic logic [39:0] pick_freq();
    int k;
    logic [63:0] span, r;
    k = $urandom_range(NUM_BANDS, 1);
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return cutoff(k);
      1: return cutoff(k) + 40'd1;
      2: return cutoff(k) - 40'd1;
      3: return 40'(r);
      4: return freq_hz;
      default: begin
        span = cutoff(k) - cutoff(k - 1) + 1;
        return cutoff(k - 1) + 40'(r % span);
      end
    endcase
  endfunction

  task automatic run_traffic(int words);
    int stop_at, n;
    logic [7:0] mode_pick;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      n = $urandom_range(99);
      if (n < 25) begin
        program_freq(pick_freq());
      end else if (n < 40) begin
        if ($urandom_range(3) != 0) begin
          read_info($urandom_range(6, 1));
        end else begin
          send_word(REQ_STOP, 8'h00);
          repeat ($urandom_range(4, 1)) send_word(REQ_READ, 8'h00);
        end
      end else if (n < 55) begin
        case ($urandom_range(4))
          0: mode_pick = MODE_OFF;
          1: mode_pick = MODE_ON;
          2, 3: mode_pick = MODE_PIN;
          default: mode_pick = 8'($urandom);
        endcase
        send_word(REQ_STOP, 8'h00);
        send_word(REQ_RECEIVE, REG_RX_MODE);
        send_word(REQ_RECEIVE, mode_pick);
        repeat ($urandom_range(4)) send_word(REQ_PIN, 8'h00);
      end else if (n < 65) begin
        send_word(REQ_STOP, 8'h00);
        send_word(REQ_RECEIVE, REG_FAN);
        repeat ($urandom_range(3, 1)) send_word(REQ_RECEIVE, 8'($urandom));
      end else if (n < 80) begin
        send_word(REQ_STOP, 8'h00);
        send_word(REQ_RECEIVE, ($urandom_range(1) != 0) ? 8'($urandom_range(3)) : 8'($urandom));
        repeat ($urandom_range(3, 1)) send_word(REQ_RECEIVE, 8'($urandom));
        repeat ($urandom_range(2)) send_word(REQ_READ, 8'h00);
      end else begin
        repeat ($urandom_range(6, 1)) send_word(req_t'($urandom_range(3)), 8'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    send_word(REQ_READ, 8'h00);
    send_word(REQ_PIN, 8'h00);
    read_info(5);
    send_word(REQ_STOP, 8'h00);
    // read after stop still uses the last selection
    send_word(REQ_READ, 8'h00);
    send_word(REQ_STOP, 8'h00);
    send_word(REQ_RECEIVE, REG_FAN);
    send_word(REQ_RECEIVE, 8'hFF);
    send_word(REQ_RECEIVE, 8'h00);
    send_word(REQ_STOP, 8'h00);
    send_word(REQ_RECEIVE, REG_RX_MODE);
    send_word(REQ_RECEIVE, MODE_ON);
    send_word(REQ_RECEIVE, MODE_PIN);
    send_word(REQ_PIN, 8'h00);
    send_word(REQ_PIN, 8'h00);
    send_word(REQ_RECEIVE, 8'h03);
    send_word(REQ_RECEIVE, MODE_OFF);
    send_word(REQ_STOP, 8'h00);
    send_word(REQ_RECEIVE, REG_UNUSED);
    send_word(REQ_RECEIVE, 8'hA5);
  endtask

  task automatic test_config();
    set_version(CFG_VERSION_MAJOR, 8'h00);
    set_version(CFG_VERSION_MINOR, 8'h00);
    read_info(2);
    set_version(CFG_VERSION_MAJOR, 8'hFF);
    set_version(CFG_VERSION_MINOR, 8'hFF);
    read_info(3);
    set_version(CFG_VERSION_MAJOR, 8'($urandom));
    set_version(CFG_VERSION_MINOR, 8'($urandom));
    read_info(2);
  endtask

  task automatic test_band_edges();
    // first write repeats the reset frequency, so the band stays put
    for (int k = 0; k <= NUM_BANDS; k++) begin
      program_freq(cutoff(k));
      if (k % 4 == 1) program_freq(cutoff(k) + 40'd1);
    end
    program_freq(40'hFF_FFFF_FFFF);
    program_freq(40'hFF_FFFF_FFFF);
    program_freq(40'd0);
  endtask

  task automatic test_read_wrap();
    read_info(262);
    send_word(REQ_STOP, 8'h00);
    send_word(REQ_READ, 8'h00);
  endtask

  task automatic test_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();
    hold_asked++;
    run_traffic(40);
    drain_results();
  endtask

  task automatic test_random_traffic();
    drain_results();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_traffic(230);
    set_version(CFG_VERSION_MAJOR, 8'($urandom));
    send_idle_pct = 83;
    recv_stall_pct = 0;
    run_traffic(230);
    set_version(CFG_VERSION_MINOR, 8'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 83;
    run_traffic(230);
    set_version(CFG_VERSION_MAJOR, 8'hFF);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    run_traffic(230);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_PIN;
    wr_data = 8'h00;
    in_pins = 5'h00;
    exttr_pin = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_VERSION_MAJOR;
    cfg_data = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config();
    test_band_edges();
    test_read_wrap();
    test_pressure();
    test_random_traffic();
    drain_results();
    repeat (LATENCY + 6) @(posedge clk);
    if (errors == 0) begin
      $display("i2c_register_io_controller verification clean");
    end else begin
      $display("i2c_register_io_controller verification failed");
    end
    $finish;
  end

endmodule
